>>> rtl/gpp_pkg.sv
// Shared types, constants and helper functions of the grid point projection block.
package gpp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1920;
  localparam int SCREEN_HEIGHT_DEF = 1080;
  localparam int TRIG_FRAC_DEF     = 14;

  localparam int COORD_W  = 33;
  localparam int COLOR_W  = 24;
  localparam int TRIG_W   = 16;
  localparam int PADDR_W  = 5;

  typedef enum logic [2:0] {
    REG_ZOOM    = 3'd0,
    REG_GAIN    = 3'd1,
    REG_MAP     = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_ROT_X   = 3'd5,
    REG_ROT_Y   = 3'd6,
    REG_ROT_Z   = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] ZOOM_RST  = 16'd1;
  localparam logic [15:0] GAIN_RST  = 16'd1;
  localparam logic [31:0] MAP_RST   = 32'd0;
  localparam logic [15:0] SHIFT_RST = 16'd0;
  localparam logic [31:0] TRIG_RST  = 32'd16384;

  typedef struct packed {
    logic               has_color;
    logic [COLOR_W-1:0] color;
  } pix_t;

  // Width of a coordinate after one rotation with 16-bit Q-format factors.
  function automatic int rot_width(input int wi, input int frac);
    rot_width = (frac < 17) ? wi + 17 - frac : wi;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic in_range;
    in_range = (&v[63:31]) || !(|v[63:31]);
    if (in_range) begin
      sat32 = v[31:0];
    end else if (v[63]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7fff_ffff;
    end
  endfunction

endpackage

>>> rtl/gpp_front.sv
// Scaling and map centering stages ahead of the rotations.
module gpp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  logic [9:0]                        col_i,
  input  logic [9:0]                        row_i,
  input  logic signed [15:0]                elev_i,
  input  gpp_pkg::pix_t                     pix_i,
  input  logic [15:0]                       zoom_i,
  input  logic [15:0]                       gain_i,
  input  logic [31:0]                       map_i,
  output logic                              valid_o,
  output logic signed [gpp_pkg::COORD_W-1:0] x_o,
  output logic signed [gpp_pkg::COORD_W-1:0] y_o,
  output logic signed [gpp_pkg::COORD_W-1:0] z_o,
  output gpp_pkg::pix_t                     pix_o
);

  localparam int CW = gpp_pkg::COORD_W;

  logic [25:0]          cz_nxt, rz_nxt;
  logic [25:0]          cz_r, rz_r;
  logic signed [CW-1:0] ez_nxt, ez_r;
  logic [31:0]          mwz, mhz;
  logic [30:0]          halfw_r, halfh_r;
  logic                 v1_r, v2_r;
  gpp_pkg::pix_t        pix1_r, pix2_r;
  logic signed [CW-1:0] x_r, y_r, z_r;

  assign cz_nxt = {16'b0, col_i} * {10'b0, zoom_i};
  assign rz_nxt = {16'b0, row_i} * {10'b0, zoom_i};
  assign ez_nxt = $signed({{(CW-16){elev_i[15]}}, elev_i}) * $signed({{(CW-16){1'b0}}, gain_i});
  assign mwz    = {16'b0, map_i[31:16]} * {16'b0, zoom_i};
  assign mhz    = {16'b0, map_i[15:0]} * {16'b0, zoom_i};

  always_ff @(posedge clk) begin
    halfw_r <= mwz[31:1];
    halfh_r <= mhz[31:1];
    cz_r    <= cz_nxt;
    rz_r    <= rz_nxt;
    ez_r    <= ez_nxt;
    pix1_r  <= pix_i;
    x_r     <= $signed({7'b0, cz_r}) - $signed({2'b0, halfw_r});
    y_r     <= $signed({7'b0, rz_r}) - $signed({2'b0, halfh_r});
    z_r     <= ez_r;
    pix2_r  <= pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  assign valid_o = v2_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign pix_o   = pix2_r;

endmodule

>>> rtl/gpp_rot.sv
// One rotation: a product stage, then a sum stage that truncates toward zero.
module gpp_rot #(
  parameter int WI       = gpp_pkg::COORD_W,
  parameter int CW       = gpp_pkg::COORD_W,
  parameter int FRAC     = gpp_pkg::TRIG_FRAC_DEF,
  parameter bit NEG_SIN  = 1'b0,
  localparam int WO      = gpp_pkg::rot_width(WI, FRAC)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [WI-1:0] a_i,
  input  logic signed [WI-1:0] b_i,
  input  logic signed [CW-1:0] c_i,
  input  gpp_pkg::pix_t        pix_i,
  input  logic [31:0]          trig_i,
  output logic                 valid_o,
  output logic signed [WO-1:0] a_o,
  output logic signed [WO-1:0] b_o,
  output logic signed [CW-1:0] c_o,
  output gpp_pkg::pix_t        pix_o
);

  localparam int WP = WI + 17;
  localparam int WS = WP + 1;

  logic signed [16:0]   cos17, sin17, sin_raw;
  logic signed [WP-1:0] a_ext, b_ext, cos_ext, sin_ext;
  logic signed [WP-1:0] pac_r, pbs_r, pbc_r, pas_r;
  logic signed [WS-1:0] sa, sb, bias_a, bias_b, ta, tb;
  logic signed [CW-1:0] c1_r, c2_r;
  gpp_pkg::pix_t        pix1_r, pix2_r;
  logic signed [WO-1:0] a_r, b_r;
  logic                 v1_r, v2_r;

  assign cos17   = $signed({trig_i[31], trig_i[31:16]});
  assign sin_raw = $signed({trig_i[15], trig_i[15:0]});
  assign sin17   = NEG_SIN ? -sin_raw : sin_raw;

  assign a_ext   = $signed({{17{a_i[WI-1]}}, a_i});
  assign b_ext   = $signed({{17{b_i[WI-1]}}, b_i});
  assign cos_ext = $signed({{WI{cos17[16]}}, cos17});
  assign sin_ext = $signed({{WI{sin17[16]}}, sin17});

  assign sa = $signed({pac_r[WP-1], pac_r}) + $signed({pbs_r[WP-1], pbs_r});
  assign sb = $signed({pbc_r[WP-1], pbc_r}) - $signed({pas_r[WP-1], pas_r});

  // Negative sums get a bias of all fraction ones so the shift rounds toward zero.
  assign bias_a = $signed({{(WS-FRAC){1'b0}}, {FRAC{sa[WS-1]}}});
  assign bias_b = $signed({{(WS-FRAC){1'b0}}, {FRAC{sb[WS-1]}}});
  assign ta     = (sa + bias_a) >>> FRAC;
  assign tb     = (sb + bias_b) >>> FRAC;

  always_ff @(posedge clk) begin
    pac_r  <= a_ext * cos_ext;
    pbs_r  <= b_ext * sin_ext;
    pbc_r  <= b_ext * cos_ext;
    pas_r  <= a_ext * sin_ext;
    c1_r   <= c_i;
    pix1_r <= pix_i;
    a_r    <= ta[WO-1:0];
    b_r    <= tb[WO-1:0];
    c2_r   <= c1_r;
    pix2_r <= pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  assign valid_o = v2_r;
  assign a_o     = a_r;
  assign b_o     = b_r;
  assign c_o     = c2_r;
  assign pix_o   = pix2_r;

endmodule

>>> rtl/grid_point_3d_projection.sv
// Top level of the grid point projection pipeline with its register port.
//
// Usage: a grid point word (column, row, elevation, optional color) is taken
// at every rising edge where start is high and busy is low. Busy stays low,
// so a new word can enter on every cycle and the sustained rate is one word
// per clock.
// Every accepted word yields exactly one result word, marked by out_valid
// for a single cycle. The pipeline registers are, in order: scaling, then
// centering; products, then sum with truncation, for each of the three
// rotations; and the screen offsets with saturation. The receiver cannot
// stall the pipeline. The user must write the registers through the APB port
// only while no word is in flight; the block itself does not enforce this.
// pready is always high and reads return the register contents.
// A synchronous reset empties the pipeline and loads the register defaults:
// unit zoom and gain, a zero map size, zero moves and zero cosine with unit
// sine for every axis.
module grid_point_3d_projection #(
  parameter int SCREEN_WIDTH   = gpp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = gpp_pkg::SCREEN_HEIGHT_DEF,
  parameter int TRIG_FRAC_BITS = gpp_pkg::TRIG_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [9:0]                   in_col,
  input  logic [9:0]                   in_row,
  input  logic signed [15:0]           in_elevation,
  input  logic                         in_has_color,
  input  logic [gpp_pkg::COLOR_W-1:0]  in_color_in,
  output logic                         out_valid,
  output logic signed [31:0]           out_screen_x,
  output logic signed [31:0]           out_screen_y,
  output logic signed [31:0]           out_depth,
  output logic [gpp_pkg::COLOR_W-1:0]  out_color_out,
  output logic                         out_need_default_color,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW  = gpp_pkg::COORD_W;
  localparam int W1  = gpp_pkg::rot_width(CW, TRIG_FRAC_BITS);
  localparam int W2  = gpp_pkg::rot_width(W1, TRIG_FRAC_BITS);
  localparam int W3  = gpp_pkg::rot_width(W2, TRIG_FRAC_BITS);
  localparam int WF  = W3 + 1;
  localparam int LAT = 9;
  localparam logic signed [16:0] HALF_W = 17'(SCREEN_WIDTH / 2);

  logic [15:0] zoom_r, gain_r, shx_r, shy_r;
  logic [31:0] map_r, trx_r, try_r, trz_r;
  logic        wr_en, accept;
  gpp_pkg::cfg_idx_t idx;

  logic signed [16:0]   offx_r;
  logic signed [32:0]   offy_r;
  logic [31:0]          hsum;

  gpp_pkg::pix_t        pix_in, pix_f, pix_x, pix_y, pix_z;
  logic                 v_f, v_x, v_y, v_z;
  logic signed [CW-1:0] x0, y0, z0, x0_c;
  logic signed [W1-1:0] y1, z1, x0_w1, y1_c;
  logic signed [W2-1:0] x1, z2, y1_w2, z2_c;
  logic signed [W3-1:0] x2, y2;
  logic signed [WF-1:0] sumx, sumy;

  logic                        out_valid_r;
  logic [31:0]                 sx_r, sy_r, dp_r;
  logic [gpp_pkg::COLOR_W-1:0] col_r;
  logic                        ndc_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = gpp_pkg::cfg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r <= gpp_pkg::ZOOM_RST;
      gain_r <= gpp_pkg::GAIN_RST;
      map_r  <= gpp_pkg::MAP_RST;
      shx_r  <= gpp_pkg::SHIFT_RST;
      shy_r  <= gpp_pkg::SHIFT_RST;
      trx_r  <= gpp_pkg::TRIG_RST;
      try_r  <= gpp_pkg::TRIG_RST;
      trz_r  <= gpp_pkg::TRIG_RST;
    end else if (wr_en) begin
      unique case (idx)
        gpp_pkg::REG_ZOOM:    zoom_r <= pwdata[15:0];
        gpp_pkg::REG_GAIN:    gain_r <= pwdata[15:0];
        gpp_pkg::REG_MAP:     map_r  <= pwdata;
        gpp_pkg::REG_SHIFT_X: shx_r  <= pwdata[15:0];
        gpp_pkg::REG_SHIFT_Y: shy_r  <= pwdata[15:0];
        gpp_pkg::REG_ROT_X:   trx_r  <= pwdata;
        gpp_pkg::REG_ROT_Y:   try_r  <= pwdata;
        gpp_pkg::REG_ROT_Z:   trz_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gpp_pkg::REG_ZOOM:    prdata = {16'b0, zoom_r};
      gpp_pkg::REG_GAIN:    prdata = {16'b0, gain_r};
      gpp_pkg::REG_MAP:     prdata = map_r;
      gpp_pkg::REG_SHIFT_X: prdata = {16'b0, shx_r};
      gpp_pkg::REG_SHIFT_Y: prdata = {16'b0, shy_r};
      gpp_pkg::REG_ROT_X:   prdata = trx_r;
      gpp_pkg::REG_ROT_Y:   prdata = try_r;
      gpp_pkg::REG_ROT_Z:   prdata = trz_r;
      default:              prdata = 32'd0;
    endcase
  end

  // Screen offsets depend on the registers alone and settle long before use.
  assign hsum = ({17'b0, map_r[15:1]} * {16'b0, zoom_r}) + 32'(SCREEN_HEIGHT);

  always_ff @(posedge clk) begin
    offx_r <= HALF_W + $signed({shx_r[15], shx_r});
    offy_r <= $signed({2'b0, hsum[31:1]}) + $signed({{17{shy_r[15]}}, shy_r});
  end

  assign pix_in.has_color = in_has_color;
  assign pix_in.color     = in_color_in;

  gpp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .col_i   (in_col),
    .row_i   (in_row),
    .elev_i  (in_elevation),
    .pix_i   (pix_in),
    .zoom_i  (zoom_r),
    .gain_i  (gain_r),
    .map_i   (map_r),
    .valid_o (v_f),
    .x_o     (x0),
    .y_o     (y0),
    .z_o     (z0),
    .pix_o   (pix_f)
  );

  gpp_rot #(.WI(CW), .CW(CW), .FRAC(TRIG_FRAC_BITS), .NEG_SIN(1'b0)) u_rot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_f),
    .a_i     (y0),
    .b_i     (z0),
    .c_i     (x0),
    .pix_i   (pix_f),
    .trig_i  (trx_r),
    .valid_o (v_x),
    .a_o     (y1),
    .b_o     (z1),
    .c_o     (x0_c),
    .pix_o   (pix_x)
  );

  assign x0_w1 = $signed({{(W1-CW){x0_c[CW-1]}}, x0_c});

  gpp_rot #(.WI(W1), .CW(W1), .FRAC(TRIG_FRAC_BITS), .NEG_SIN(1'b0)) u_rot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_x),
    .a_i     (x0_w1),
    .b_i     (z1),
    .c_i     (y1),
    .pix_i   (pix_x),
    .trig_i  (try_r),
    .valid_o (v_y),
    .a_o     (x1),
    .b_o     (z2),
    .c_o     (y1_c),
    .pix_o   (pix_y)
  );

  assign y1_w2 = $signed({{(W2-W1){y1_c[W1-1]}}, y1_c});

  gpp_rot #(.WI(W2), .CW(W2), .FRAC(TRIG_FRAC_BITS), .NEG_SIN(1'b1)) u_rot_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v_y),
    .a_i     (x1),
    .b_i     (y1_w2),
    .c_i     (z2),
    .pix_i   (pix_y),
    .trig_i  (trz_r),
    .valid_o (v_z),
    .a_o     (x2),
    .b_o     (y2),
    .c_o     (z2_c),
    .pix_o   (pix_z)
  );

  assign sumx = $signed({x2[W3-1], x2}) + $signed({{(WF-17){offx_r[16]}}, offx_r});
  assign sumy = $signed({y2[W3-1], y2}) + $signed({{(WF-33){offy_r[32]}}, offy_r});

  always_ff @(posedge clk) begin
    sx_r  <= gpp_pkg::sat32($signed({{(64-WF){sumx[WF-1]}}, sumx}));
    sy_r  <= gpp_pkg::sat32($signed({{(64-WF){sumy[WF-1]}}, sumy}));
    dp_r  <= gpp_pkg::sat32($signed({{(64-W2){z2_c[W2-1]}}, z2_c}));
    col_r <= pix_z.has_color ? pix_z.color : '0;
    ndc_r <= !pix_z.has_color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_z;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_screen_x           = sx_r;
  assign out_screen_y           = sy_r;
  assign out_depth              = dp_r;
  assign out_color_out          = col_r;
  assign out_need_default_color = ndc_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result word without an accepted input word");

  a_default_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_need_default_color) |-> (out_color_out == '0))
    else $error("color given while default color is requested");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the grid point projection block with its APB register port.
`timescale 1ns / 100ps

module tb;
  import gpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam longint TRIG_ONE   = longint'(1) << TRIG_FRAC_DEF;

  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [15:0] elevation;
    logic               has_color;
    logic [COLOR_W-1:0] color;
  } grid_point_t;

  typedef struct packed {
    logic [31:0]        screen_x;
    logic [31:0]        screen_y;
    logic [31:0]        depth;
    logic [COLOR_W-1:0] color_out;
    logic               need_default;
  } projection_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] in_col = '0;
  logic [9:0] in_row = '0;
  logic signed [15:0] in_elevation = '0;
  logic in_has_color = 1'b0;
  logic [COLOR_W-1:0] in_color_in = '0;
  logic out_valid;
  logic signed [31:0] out_screen_x;
  logic signed [31:0] out_screen_y;
  logic signed [31:0] out_depth;
  logic [COLOR_W-1:0] out_color_out;
  logic out_need_default_color;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] zoom_r = ZOOM_RST;
  logic [15:0] gain_r = GAIN_RST;
  logic [31:0] map_r = MAP_RST;
  logic [15:0] shift_x_r = SHIFT_RST;
  logic [15:0] shift_y_r = SHIFT_RST;
  logic [31:0] trig_x_r = TRIG_RST;
  logic [31:0] trig_y_r = TRIG_RST;
  logic [31:0] trig_z_r = TRIG_RST;

  projection_t pending_q[$];
  projection_t want;
  int errors = 0;
  int n_points = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_colored = 0;
  int idle_count = 0;

  grid_point_3d_projection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_col(in_col), .in_row(in_row), .in_elevation(in_elevation),
    .in_has_color(in_has_color), .in_color_in(in_color_in),
    .out_valid(out_valid), .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_depth(out_depth), .out_color_out(out_color_out),
    .out_need_default_color(out_need_default_color),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void rotate_plane(inout longint a, inout longint b,
                                       input longint c, input longint s);
    longint p, q;
    p = a;
    q = b;
    a = (p * c + q * s) / TRIG_ONE;
    b = (q * c - p * s) / TRIG_ONE;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic projection_t project_point(grid_point_t p);
    projection_t r;
    longint zm, mw, mh, x, y, z, c, s;
    zm = zoom_r;
    mw = map_r[31:16];
    mh = map_r[15:0];
    x = longint'(p.col) * zm - (mw * zm) / 2;
    y = longint'(p.row) * zm - (mh * zm) / 2;
    z = longint'(p.elevation) * longint'(gain_r);
    c = $signed(trig_x_r[31:16]);
    s = $signed(trig_x_r[15:0]);
    rotate_plane(y, z, c, s);
    c = $signed(trig_y_r[31:16]);
    s = $signed(trig_y_r[15:0]);
    rotate_plane(x, z, c, s);
    c = $signed(trig_z_r[31:16]);
    s = $signed(trig_z_r[15:0]);
    rotate_plane(x, y, c, -s);
    x = x + SCREEN_WIDTH_DEF / 2 + longint'($signed(shift_x_r));
    y = y + (longint'(SCREEN_HEIGHT_DEF) + (mh / 2) * zm) / 2 + longint'($signed(shift_y_r));
    r.screen_x = clamp32(x);
    r.screen_y = clamp32(y);
    r.depth = clamp32(z);
    r.color_out = p.has_color ? p.color : '0;
    r.need_default = !p.has_color;
    return r;
  endfunction

  task automatic send_point(grid_point_t p);
    start <= 1'b1;
    in_col <= p.col;
    in_row <= p.row;
    in_elevation <= p.elevation;
    in_has_color <= p.has_color;
    in_color_in <= p.color;
    do @(posedge clk); while (busy !== 1'b0);
    pending_q.push_back(project_point(p));
    n_points++;
    if (p.has_color) n_colored++;
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Consecutive writes keep psel high, so each bus signal changes once per edge.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_ZOOM:    zoom_r = value[15:0];
      REG_GAIN:    gain_r = value[15:0];
      REG_MAP:     map_r = value;
      REG_SHIFT_X: shift_x_r = value[15:0];
      REG_SHIFT_Y: shift_y_r = value[15:0];
      REG_ROT_X:   trig_x_r = value;
      REG_ROT_Y:   trig_y_r = value;
      REG_ROT_Z:   trig_z_r = value;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic configure(logic [15:0] zm, logic [15:0] gn, logic [31:0] map,
                           logic [15:0] sx, logic [15:0] sy,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    wait_drain();
    write_reg(REG_ZOOM, {16'h0, zm});
    write_reg(REG_GAIN, {16'h0, gn});
    write_reg(REG_MAP, map);
    write_reg(REG_SHIFT_X, {16'h0, sx});
    write_reg(REG_SHIFT_Y, {16'h0, sy});
    write_reg(REG_ROT_X, tx);
    write_reg(REG_ROT_Y, ty);
    write_reg(REG_ROT_Z, tz);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'hffff;
      5: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    logic [15:0] c, s;
    if ($urandom_range(0, 1)) begin
      c = 16'($signed($urandom_range(0, 32768)) - 16384);
      s = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else begin
      c = pick_half();
      s = pick_half();
    end
    return {c, s};
  endfunction

  function automatic logic [31:0] pick_map();
    if ($urandom_range(0, 2) != 0) begin
      return {16'($urandom_range(2, 1024)), 16'($urandom_range(2, 1024))};
    end
    return {pick_half(), pick_half()};
  endfunction

  function automatic grid_point_t random_point();
    grid_point_t p;
    p.col = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'h3ff : 10'h0)
                                         : 10'($urandom);
    p.row = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'h3ff : 10'h0)
                                         : 10'($urandom);
    p.elevation = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000)
                                               : 16'($urandom);
    p.has_color = 1'($urandom_range(0, 1));
    p.color = 24'($urandom);
    return p;
  endfunction

  task automatic send_bursts(int count, bit with_gaps, bit hold_midway);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        send_point(random_point());
        burst--;
        left--;
      end
      if (hold_midway && left < count / 2) begin
        wait_drain();
        hold_midway = 1'b0;
      end else if (with_gaps && left > 0) begin
        pause_sender($urandom_range(1, 10));
      end
    end
  endtask

  task automatic test_default_registers();
    send_point('{10'd0, 10'd0, 16'sd0, 1'b0, 24'h000000});
    send_point('{10'h3ff, 10'h3ff, 16'sh7fff, 1'b1, 24'hffffff});
    send_point('{10'd0, 10'h3ff, -16'sh8000, 1'b1, 24'h000000});
    send_point('{10'h3ff, 10'd0, -16'sd1, 1'b0, 24'habcdef});
  endtask

  task automatic test_extreme_registers();
    configure(16'hffff, 16'hffff, 32'hffff_ffff, 16'h8000, 16'h7fff,
              32'h8000_8000, 32'h7fff_7fff, 32'h8000_7fff);
    send_point('{10'h3ff, 10'h3ff, 16'sh7fff, 1'b1, 24'h123456});
    send_point('{10'd0, 10'd0, -16'sh8000, 1'b0, 24'hffffff});
    send_point('{10'h3ff, 10'd0, -16'sh8000, 1'b1, 24'hfedcba});
    send_point('{10'd0, 10'h3ff, 16'sh7fff, 1'b0, 24'h000001});
    configure(16'h0001, 16'h0001, 32'h0000_0000, 16'h7fff, 16'h8000,
              32'h4000_0000, 32'h7fff_8000, 32'h4000_0000);
    send_point('{10'h3ff, 10'h3ff, 16'sh7fff, 1'b1, 24'h800000});
    send_point('{10'd0, 10'd0, -16'sh8000, 1'b0, 24'h7fffff});
    send_point('{10'h155, 10'h2aa, 16'sh5555, 1'b1, 24'h555555});
    send_point('{10'h2aa, 10'h155, -16'sh5556, 1'b1, 24'haaaaaa});
  endtask

  task automatic test_zero_scale();
    configure(16'h0000, 16'h0000, 32'h0400_0400, 16'h0000, 16'h0000,
              32'h2d41_2d41, 32'h3b21_187e, 32'h187e_c4df);
    send_point('{10'h3ff, 10'h3ff, 16'sh7fff, 1'b0, 24'h000000});
    send_point('{10'd0, 10'd0, -16'sh8000, 1'b1, 24'h00ff00});
    send_point('{10'h200, 10'h100, 16'sd100, 1'b0, 24'h0000ff});
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      configure(pick_half(), pick_half(), pick_map(), pick_half(), pick_half(),
                pick_trig(), pick_trig(), pick_trig());
      send_bursts(155, phase != 0, phase == 3);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_q.size() == 0) begin
        $error("result word with no projection pending");
        errors++;
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (out_screen_x !== want.screen_x) begin
          $error("screen_x expected %0d got %0d", $signed(want.screen_x), out_screen_x);
          errors++;
        end
        if (out_screen_y !== want.screen_y) begin
          $error("screen_y expected %0d got %0d", $signed(want.screen_y), out_screen_y);
          errors++;
        end
        if (out_depth !== want.depth) begin
          $error("depth expected %0d got %0d", $signed(want.depth), out_depth);
          errors++;
        end
        if (out_color_out !== want.color_out) begin
          $error("color_out expected %06h got %06h", want.color_out, out_color_out);
          errors++;
        end
        if (out_need_default_color !== want.need_default) begin
          $error("need_default_color expected %0b got %0b", want.need_default,
                 out_need_default_color);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (psel && penable && pready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_extreme_registers();
    test_zero_scale();
    test_random_settings();
    wait_drain();
    if (pending_q.size() != 0) begin
      $error("%0d projections never came out", pending_q.size());
      errors++;
    end
    $display("Run covered %0d grid points (%0d with a given color) and %0d register writes,",
             n_points, n_colored, n_writes);
    $display("with %0d result words checked and %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
